>>> rtl/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg
// shared constants, codes and types of the sorted list store
// ----------------------------------------------------------------------------
package sls_pkg;

   localparam int DEPTH       = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int OP_W        = 3;
   localparam int COUNT_OUT_W = 6;
   localparam int STATUS_W    = 2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_DELETE    = 3'd1,
      OP_COUNT     = 3'd2,
      OP_ASC_DUMP  = 3'd3,
      OP_DESC_DUMP = 3'd4,
      OP_ALT_DUMP  = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_DUMP
   } fsm_state_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROT_LEFT,
      CMD_ROT_RIGHT
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic      valid;
      logic      gt;
      value_type value;
   } link_type;

endpackage

>>> rtl/sls_req_if.sv
// ----------------------------------------------------------------------------
// sls_req_if
// request channel: operation and value words with valid/ready
// ----------------------------------------------------------------------------
interface sls_req_if;
   import sls_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

>>> rtl/sls_rsp_if.sv
// ----------------------------------------------------------------------------
// sls_rsp_if
// response channel: result words with valid/ready
// ----------------------------------------------------------------------------
interface sls_rsp_if;
   import sls_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] item_value;
   logic [COUNT_OUT_W-1:0]    entry_count;
   logic [STATUS_W-1:0]       status;
   logic                      last;

   modport source (output valid, output item_value, output entry_count, output status,
                   output last, input ready);
   modport sink   (input valid, input item_value, input entry_count, input status,
                   input last, output ready);
endinterface

>>> rtl/sls_cell.sv
// ----------------------------------------------------------------------------
// sls_cell
// one slot of the sorted row: holds a value, compares it to the key and
// shifts toward either neighbor on command
// ----------------------------------------------------------------------------
module sls_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sls_pkg::cell_cmd_type cmd,
   input  sls_pkg::value_type   key,
   input  sls_pkg::link_type    left_link,
   input  sls_pkg::link_type    right_link,
   input  sls_pkg::value_type   head_value,
   output sls_pkg::link_type    link,
   output logic                 match
);
   import sls_pkg::*;

   value_type value_ff, value_in;
   logic      valid_ff, valid_in;
   logic      ge;

   assign link.valid = valid_ff;
   assign link.value = value_ff;
   assign link.gt    = valid_ff && (value_ff > key);
   assign ge         = valid_ff && (value_ff >= key);
   assign match      = valid_ff && (value_ff == key);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (cmd)
         CMD_INSERT: begin
            // cells at or past the insert point move right by one
            if (!valid_ff || link.gt) begin
               value_in = left_link.gt ? left_link.value : key;
               valid_in = valid_ff || left_link.valid;
            end
         end
         CMD_DELETE: begin
            // from the first match on, pull in the right neighbor
            if (ge) begin
               value_in = right_link.value;
               valid_in = right_link.valid;
            end
         end
         CMD_ROT_LEFT: begin
            if (valid_ff) begin
               value_in = right_link.valid ? right_link.value : head_value;
            end
         end
         CMD_ROT_RIGHT: begin
            if (valid_ff) begin
               value_in = left_link.value;
            end
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

>>> rtl/sorted_list_store.sv
// insert, delete, count and unused codes: result word in the cycle after accept,
//    one request word per cycle while result words are taken
// dumps: the first dump step loads the first word, then one rotation step per cycle,
//    n steps for n entries (a word per step, every second step for the alternate dump)
// a waiting result word holds the next emitting step and the request side until taken
// reset (synchronous) empties the store at once; entry contents stay unset
// ----------------------------------------------------------------------------
// sorted_list_store
// ascending list of signed words kept in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
module sorted_list_store (
   input  logic      clock,
   input  logic      reset,
   sls_req_if.sink   req,
   sls_rsp_if.source rsp
);
   import sls_pkg::*;

   // row of cells
   cell_cmd_type     cell_cmd;
   link_type         links [DEPTH];
   logic [DEPTH-1:0] match_vec;
   logic [DEPTH-1:0] valid_vec;
   value_type        head_value;
   value_type        tail_value;
   logic             found;

   // control
   fsm_state_type state_ff, state_in;
   count_type     count_ff, count_in;
   count_type     step_ff, step_in;
   opcode_type    dump_op_ff, dump_op_in;
   opcode_type    op;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   value_type      rsp_value_ff, rsp_value_in;
   count_type      rsp_count_ff, rsp_count_in;
   status_type     rsp_status_ff, rsp_status_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           load_rsp;
   logic           can_load;
   logic           accept;
   logic           dump_done;
   logic           emit;
   logic           advance;
   logic [CNT_W:0] step_plus_two;

   assign op = opcode_type'(req.operation);

   // ---- cell row ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type left_link;
      link_type right_link;

      if (i == 0) begin : g_first
         // head cell sees the tail across the wrap when rotating right
         assign left_link = '{valid: 1'b1, gt: 1'b0, value: tail_value};
      end else begin : g_mid_left
         assign left_link = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_link = '{valid: 1'b0, gt: 1'b0, value: head_value};
      end else begin : g_mid_right
         assign right_link = links[i+1];
      end

      sls_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .key        (req.value),
         .left_link  (left_link),
         .right_link (right_link),
         .head_value (head_value),
         .link       (links[i]),
         .match      (match_vec[i])
      );

      assign valid_vec[i] = links[i].valid;
   end

   assign head_value = links[0].value;
   assign found      = |match_vec;

   // tail is the one valid cell whose right neighbor is empty
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_vec[i] && ((i == DEPTH - 1) || !valid_vec[(i + 1) % DEPTH])) begin
            tail_value = tail_value | links[i].value;
         end
      end
   end

   // ---- handshake ----
   assign can_load  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == FSM_IDLE) && can_load;
   assign accept    = req.valid && req.ready;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && (count_ff != '0) &&
                (op == OP_ASC_DUMP || op == OP_DESC_DUMP || op == OP_ALT_DUMP)) begin
               state_in = FSM_DUMP;
            end
         end
         FSM_DUMP: begin
            if (dump_done) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // ---- outputs of the sequencer ----
   assign step_plus_two = {1'b0, step_ff} + (CNT_W + 1)'(2);

   always_comb begin
      cell_cmd      = CMD_HOLD;
      count_in      = count_ff;
      step_in       = step_ff;
      dump_op_in    = dump_op_ff;
      load_rsp      = 1'b0;
      rsp_value_in  = '0;
      rsp_count_in  = count_ff;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;
      emit          = 1'b0;
      advance       = 1'b0;
      dump_done     = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               load_rsp = 1'b1;
               case (op)
                  OP_INSERT: begin
                     if (count_ff == count_type'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cell_cmd = CMD_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (found) begin
                        cell_cmd = CMD_DELETE;
                        count_in = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_ASC_DUMP, OP_DESC_DUMP, OP_ALT_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // words come from the dump steps
                        load_rsp   = 1'b0;
                        step_in    = '0;
                        dump_op_in = op;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         FSM_DUMP: begin
            // alternate dump only sends on even steps
            emit    = (dump_op_ff != OP_ALT_DUMP) || !step_ff[0];
            advance = emit ? can_load : 1'b1;
            if (advance) begin
               cell_cmd     = (dump_op_ff == OP_DESC_DUMP) ? CMD_ROT_RIGHT : CMD_ROT_LEFT;
               load_rsp     = emit;
               rsp_value_in = (dump_op_ff == OP_DESC_DUMP) ? tail_value : head_value;
               if (dump_op_ff == OP_ALT_DUMP) begin
                  rsp_last_in = step_plus_two >= {1'b0, count_ff};
               end else begin
                  rsp_last_in = count_type'(step_ff + 1'b1) == count_ff;
               end
               step_in   = step_ff + 1'b1;
               dump_done = count_type'(step_ff + 1'b1) == count_ff;
            end
         end
         default: begin
            cell_cmd = CMD_HOLD;
         end
      endcase
   end

   // result word stays until taken
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff    <= step_in;
      dump_op_ff <= dump_op_in;
      if (load_rsp) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.item_value  = rsp_value_ff;
   assign rsp.entry_count = COUNT_OUT_W'(rsp_count_ff);
   assign rsp.status      = rsp_status_ff;
   assign rsp.last        = rsp_last_ff;

   // ---- checks ----
   // occupancy never runs past the row
   assert property (@(posedge clock) disable iff (reset) count_ff <= count_type'(DEPTH))
      else $error("occupancy above depth");

   // filled cells form one block from the head
   assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("gap in the cell row");

   // filled cells agree with the occupancy count
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell fill and count disagree");

   // a dump step never runs past the stored entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_DUMP) |-> (step_ff < count_ff))
      else $error("dump step out of range");

   // a word waiting on the result side is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !load_rsp)
      else $error("result word overwritten");

endmodule
